// ===== rtl/aesd_pkg.sv =====
// aesd_pkg: shared types, constants and round functions for the aes-128 decrypt unit
// no dependencies
package aesd_pkg;

    localparam int unsigned NUM_ROUNDS = 10;
    localparam int unsigned BLOCK_W    = 128;
    localparam int unsigned HALF_W     = 64;
    localparam int unsigned CFG_IDX_W  = 1;

    typedef logic [BLOCK_W-1:0] block_t;
    typedef logic [HALF_W-1:0]  half_t;
    typedef logic [7:0]         byte_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_HIGH = 1'b0,
        REG_KEY_LOW  = 1'b1
    } cfg_reg_t;

    localparam byte_t RCON [NUM_ROUNDS] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
    };

    localparam byte_t FWD_SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam byte_t INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    // multiply by x in gf(2^8)
    function automatic byte_t xtime(input byte_t a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // next round key from the previous one (forward schedule step)
    function automatic block_t next_round_key(input block_t k, input byte_t rc);
        logic [31:0] t;
        logic [31:0] w0, w1, w2, w3;
        t = {FWD_SBOX[k[23:16]], FWD_SBOX[k[15:8]], FWD_SBOX[k[7:0]], FWD_SBOX[k[31:24]]};
        t = t ^ {rc, 24'h0};
        w0 = k[127:96] ^ t;
        w1 = k[95:64] ^ w0;
        w2 = k[63:32] ^ w1;
        w3 = k[31:0] ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    // inverse shift rows and inverse sub bytes; byte n sits at bits 127-8n
    function automatic block_t inv_shift_sub(input block_t s);
        block_t o;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                o[BLOCK_W-1-8*(r+4*c) -: 8] =
                    INV_SBOX[s[BLOCK_W-1-8*(r+4*(((c-r)+4)%4)) -: 8]];
            end
        end
        return o;
    endfunction

    // inverse mix columns
    function automatic block_t inv_mix_columns(input block_t s);
        block_t o;
        byte_t a [4];
        byte_t x2 [4];
        byte_t x4 [4];
        byte_t x8 [4];
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) begin
                a[k]  = s[BLOCK_W-1-8*(k+4*c) -: 8];
                x2[k] = xtime(a[k]);
                x4[k] = xtime(x2[k]);
                x8[k] = xtime(x4[k]);
            end
            for (int r = 0; r < 4; r++) begin
                o[BLOCK_W-1-8*(r+4*c) -: 8] =
                    (x8[r%4] ^ x4[r%4] ^ x2[r%4]) ^
                    (x8[(r+1)%4] ^ x2[(r+1)%4] ^ a[(r+1)%4]) ^
                    (x8[(r+2)%4] ^ x4[(r+2)%4] ^ a[(r+2)%4]) ^
                    (x8[(r+3)%4] ^ a[(r+3)%4]);
            end
        end
        return o;
    endfunction

endpackage

// ===== rtl/aesd_stream_if.sv =====
// aesd_stream_if: valid/ready channel carrying one 128-bit block as two halves
// depends on aesd_pkg
interface aesd_stream_if
    import aesd_pkg::*;
();
    logic  valid;
    logic  ready;
    half_t high;
    half_t low;

    modport source (output valid, output high, output low, input ready);
    modport sink (input valid, input high, input low, output ready);
endinterface

// ===== rtl/aesd_key_sched.sv =====
// aesd_key_sched: holds the key and its 11 expanded round keys
// depends on aesd_pkg
module aesd_key_sched
    import aesd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  half_t                cfg_data,
    output block_t               round_keys [NUM_ROUNDS+1],
    output logic                 keys_ready
);

    localparam int unsigned SETTLE = NUM_ROUNDS + 1;

    half_t  key_high_reg;
    half_t  key_low_reg;
    block_t rk_reg [NUM_ROUNDS+1];
    block_t rk_next [NUM_ROUNDS+1];
    logic [3:0] settle_cnt_reg;

    // key registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_idx))
                REG_KEY_HIGH: key_high_reg <= cfg_data;
                REG_KEY_LOW:  key_low_reg  <= cfg_data;
                default:      key_high_reg <= key_high_reg;
            endcase
        end
    end

    // cycles left until every round key holds the current key's schedule
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_cnt_reg <= 4'(SETTLE);
        end
        else if (cfg_we)
        begin
            settle_cnt_reg <= 4'(SETTLE);
        end
        else if (settle_cnt_reg != 4'd0)
        begin
            settle_cnt_reg <= settle_cnt_reg - 4'd1;
        end
    end

    assign keys_ready = (settle_cnt_reg == 4'd0) && !cfg_we;

    // one schedule step per round key, each taken from the previous registered round key
    always_comb
    begin
        rk_next[0] = rk_reg[0];
        rk_next[0] = {key_high_reg, key_low_reg};
        for (int r = 1; r <= NUM_ROUNDS; r++)
        begin
            rk_next[r] = next_round_key(rk_reg[r-1], RCON[r-1]);
        end
    end

    // round keys ripple one step per cycle; input is held off until settled
    always_ff @(posedge clk)
    begin
        for (int r = 0; r <= NUM_ROUNDS; r++)
        begin
            rk_reg[r] <= rk_next[r];
        end
    end

    assign round_keys = rk_reg;

endmodule

// ===== rtl/aes128_block_decrypt_unit.sv =====
// aes128_block_decrypt_unit: pipelined aes-128 ecb decryption
// depends on aesd_pkg, aesd_stream_if, aesd_key_sched
//
// Fully pipelined AES-128 inverse cipher: the initial key add is one stage and
// each of the ten inverse rounds has a stage of its own, so a word enters every
// cycle while the pipeline advances and the keys are settled; the whole pipeline
// halts while the output word is not taken. The key is written through the config
// port (index 0 key bytes 0..7, index 1 bytes 8..15); the round keys are rebuilt
// one round per cycle, so after reset and after each key write the input is not
// ready while the schedule settles.
module aes128_block_decrypt_unit
    import aesd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    aesd_stream_if.sink          cipher,
    aesd_stream_if.source        plain,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  half_t                cfg_data
);

    localparam int unsigned STAGES = NUM_ROUNDS + 1;

    block_t round_keys [NUM_ROUNDS+1];
    block_t state_reg [STAGES];
    logic   valid_reg [STAGES];
    logic   advance;
    logic   keys_ready;

    aesd_key_sched u_key_sched (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_idx    (cfg_idx),
        .cfg_data   (cfg_data),
        .round_keys (round_keys),
        .keys_ready (keys_ready)
    );

    // pipeline moves whenever the last stage is empty or taken
    assign advance      = !valid_reg[STAGES-1] || plain.ready;
    assign cipher.ready = advance && keys_ready;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < STAGES; s++)
            begin
                valid_reg[s] <= 1'b0;
            end
        end
        else if (advance)
        begin
            valid_reg[0] <= cipher.valid && keys_ready;
            for (int s = 1; s < STAGES; s++)
            begin
                valid_reg[s] <= valid_reg[s-1];
            end
        end
    end

    // datapath: stage 0 adds key 10, stage s runs the round using key 10-s
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            state_reg[0] <= {cipher.high, cipher.low} ^ round_keys[NUM_ROUNDS];
            for (int s = 1; s < STAGES - 1; s++)
            begin
                state_reg[s] <= inv_mix_columns(
                    inv_shift_sub(state_reg[s-1]) ^ round_keys[NUM_ROUNDS-s]);
            end
            state_reg[STAGES-1] <= inv_shift_sub(state_reg[STAGES-2]) ^ round_keys[0];
        end
    end

    assign plain.valid = valid_reg[STAGES-1];
    assign plain.high  = state_reg[STAGES-1][BLOCK_W-1:HALF_W];
    assign plain.low   = state_reg[STAGES-1][HALF_W-1:0];

endmodule

// ===== tb/aesd_tb_pkg.sv =====
// aesd_tb_pkg: expected-plaintext computation for the aes-128 decrypt unit testbench
// depends on aesd_pkg for block, half and byte types only
`timescale 1ns / 100ps
package aesd_tb_pkg;
    import aesd_pkg::*;

    typedef logic [31:0] rk_word_t;

    // forward and inverse substitution, computed from gf(2^8) inverse and affine map
    function automatic byte_t gmul(input byte_t a, input byte_t b);
        byte_t p;
        byte_t x;
        byte_t y;
        p = 8'h00;
        x = a;
        y = b;
        for (int i = 0; i < 8; i++)
        begin
            if (y[0])
                p = p ^ x;
            x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
            y = y >> 1;
        end
        return p;
    endfunction

    function automatic byte_t ginv(input byte_t a);
        byte_t r;
        r = 8'h01;
        // a^254 is the multiplicative inverse, zero maps to zero
        for (int i = 0; i < 254; i++)
            r = gmul(r, a);
        return (a == 8'h00) ? 8'h00 : r;
    endfunction

    function automatic byte_t sub_fwd(input byte_t a);
        byte_t b;
        byte_t o;
        byte_t aff;
        aff = 8'h63;
        b = ginv(a);
        for (int i = 0; i < 8; i++)
            o[i] = b[i] ^ b[(i+4)%8] ^ b[(i+5)%8] ^ b[(i+6)%8] ^ b[(i+7)%8] ^ aff[i];
        return o;
    endfunction

    // forward sbox table from sub_fwd and inverse sbox table built once by inverting the forward map
    function automatic void build_sboxes(ref byte_t fwd [256], ref byte_t inv [256]);
        for (int i = 0; i < 256; i++)
        begin
            fwd[i] = sub_fwd(byte_t'(i));
            inv[fwd[i]] = byte_t'(i);
        end
    endfunction

    // 44-word schedule from the current key register pair
    function automatic void expand_schedule(input half_t k_hi, input half_t k_lo,
                                            ref byte_t fwd [256], ref rk_word_t rk [44]);
        rk_word_t t;
        byte_t rcon;
        rcon = 8'h01;
        rk[0] = k_hi[63:32];
        rk[1] = k_hi[31:0];
        rk[2] = k_lo[63:32];
        rk[3] = k_lo[31:0];
        for (int i = 4; i < 44; i++)
        begin
            t = rk[i-1];
            if (i % 4 == 0)
            begin
                t = {t[23:0], t[31:24]};
                t = {fwd[t[31:24]], fwd[t[23:16]], fwd[t[15:8]], fwd[t[7:0]]};
                t = t ^ {rcon, 24'h0};
                rcon = gmul(rcon, 8'h02);
            end
            rk[i] = rk[i-4] ^ t;
        end
    endfunction

    // full inverse cipher on one block, byte n at bits 127-8n
    function automatic block_t decrypt_block(input block_t ct, ref byte_t inv [256],
                                             ref rk_word_t rk [44]);
        byte_t s [16];
        byte_t t [16];
        byte_t coef [4];
        block_t o;
        coef = '{8'd14, 8'd11, 8'd13, 8'd9};
        for (int n = 0; n < 16; n++)
            s[n] = ct[127-8*n -: 8];
        for (int rnd = 10; rnd >= 0; rnd--)
        begin
            if (rnd < 10)
            begin
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++)
                        t[r+4*c] = inv[s[r+4*((c-r+4)%4)]];
                s = t;
            end
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    s[r+4*c] = s[r+4*c] ^ rk[rnd*4+c][31-8*r -: 8];
            if (rnd > 0 && rnd < 10)
            begin
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++)
                    begin
                        t[r+4*c] = 8'h00;
                        for (int k = 0; k < 4; k++)
                            t[r+4*c] = t[r+4*c] ^ gmul(s[k+4*c], coef[(k-r+4)%4]);
                    end
                s = t;
            end
        end
        for (int n = 0; n < 16; n++)
            o[127-8*n -: 8] = s[n];
        return o;
    endfunction
endpackage

// ===== tb/aes128_block_decrypt_unit_tb.sv =====
// aes128_block_decrypt_unit_tb: random and directed ecb decryption checks with key phases
// depends on aesd_pkg, aesd_stream_if, aesd_tb_pkg and the unit under test
`timescale 1ns / 100ps
module aes128_block_decrypt_unit_tb;
    import aesd_pkg::*;
    import aesd_tb_pkg::*;

    logic clk;
    logic rst_n;
    logic cfg_we;
    cfg_reg_t cfg_idx;
    half_t cfg_data;

    aesd_stream_if cipher_ch ();
    aesd_stream_if plain_ch ();

    aes128_block_decrypt_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cipher   (cipher_ch.sink),
        .plain    (plain_ch.source),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    byte_t fwd_tab [256];
    byte_t inv_tab [256];
    rk_word_t sched [44];
    half_t key_hi;
    half_t key_lo;
    block_t cipher_words [$];
    block_t plain_expected [$];
    int errors;
    bit gate_open;
    int burst_left;
    int gap_left;
    int stall_phase;

    // clock
    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    task automatic report_mismatch(input string what, input half_t got, input half_t want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    // driver: bursts of words with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cipher_ch.valid <= 1'b0;
            cipher_ch.high <= '0;
            cipher_ch.low <= '0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (cipher_ch.valid && cipher_ch.ready)
            begin
                plain_expected.push_back(decrypt_block({cipher_ch.high, cipher_ch.low},
                                                       inv_tab, sched));
                void'(cipher_words.pop_front());
            end
            if (!(cipher_ch.valid && !cipher_ch.ready))
            begin
                if (gap_left > 0)
                    gap_left--;
                if (gate_open && cipher_words.size() > 0 && gap_left == 0)
                begin
                    cipher_ch.valid <= 1'b1;
                    cipher_ch.high <= cipher_words[0][127:64];
                    cipher_ch.low <= cipher_words[0][63:0];
                    if (burst_left == 0)
                        burst_left = $urandom_range(1, 30);
                    burst_left--;
                    if (burst_left == 0)
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
                end
                else
                    cipher_ch.valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern and result check
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plain_ch.ready <= 1'b0;
            stall_phase = 0;
        end
        else
        begin
            if (plain_ch.valid && plain_ch.ready)
            begin
                if (plain_expected.size() == 0)
                begin
                    report_mismatch("unexpected word", plain_ch.high, plain_ch.low);
                end
                else
                begin
                    block_t want;
                    want = plain_expected.pop_front();
                    if (plain_ch.high !== want[127:64])
                        report_mismatch("plain_high", plain_ch.high, want[127:64]);
                    if (plain_ch.low !== want[63:0])
                        report_mismatch("plain_low", plain_ch.low, want[63:0]);
                end
            end
            stall_phase = (stall_phase + 1) % 200;
            if (stall_phase < 60)
                plain_ch.ready <= 1'b1;
            else if (stall_phase < 120)
                plain_ch.ready <= ($urandom_range(0, 3) != 0);
            else
                plain_ch.ready <= ($urandom_range(0, 2) == 0);
        end
    end

    task automatic wait_drained();
        while (cipher_words.size() > 0 || cipher_ch.valid || plain_expected.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_key(input cfg_reg_t idx, input half_t value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_KEY_HIGH)
            key_hi = value;
        else
            key_lo = value;
        expand_schedule(key_hi, key_lo, fwd_tab, sched);
        // round keys rebuild one round per cycle
        repeat (15) @(posedge clk);
    endtask

    function automatic half_t rand_half();
        return {$urandom(), $urandom()};
    endfunction

    task automatic run_random(input int count);
        gate_open = 1'b1;
        for (int i = 0; i < count; i++)
            cipher_words.push_back({rand_half(), rand_half()});
        wait_drained();
    endtask

    // stimulus
    initial
    begin
        errors = 0;
        gate_open = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = REG_KEY_HIGH;
        cfg_data = '0;
        build_sboxes(fwd_tab, inv_tab);
        key_hi = '0;
        key_lo = '0;
        expand_schedule(key_hi, key_lo, fwd_tab, sched);
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        repeat (15) @(posedge clk);

        // decrypt with the reset key, field extremes
        gate_open = 1'b1;
        cipher_words.push_back('0);
        cipher_words.push_back('1);
        cipher_words.push_back({64'h0, 64'hffff_ffff_ffff_ffff});
        cipher_words.push_back({64'hffff_ffff_ffff_ffff, 64'h0});
        cipher_words.push_back({64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555});
        wait_drained();

        // standard test vector key, partial write first
        write_key(REG_KEY_HIGH, 64'h0001_0203_0405_0607);
        cipher_words.push_back({64'h69c4_e0d8_6a7b_0430, 64'hd8cd_b780_70b4_c55a});
        wait_drained();
        write_key(REG_KEY_LOW, 64'h0809_0a0b_0c0d_0e0f);
        cipher_words.push_back({64'h69c4_e0d8_6a7b_0430, 64'hd8cd_b780_70b4_c55a});
        cipher_words.push_back('0);
        cipher_words.push_back('1);
        wait_drained();

        // all-ones key
        write_key(REG_KEY_HIGH, '1);
        write_key(REG_KEY_LOW, '1);
        cipher_words.push_back('0);
        cipher_words.push_back('1);
        cipher_words.push_back({rand_half(), rand_half()});
        wait_drained();

        // random phases with random keys, extremes included
        for (int ph = 0; ph < 5; ph++)
        begin
            write_key(REG_KEY_HIGH, (ph == 0) ? '0 : rand_half());
            write_key(REG_KEY_LOW, (ph == 0) ? '1 : rand_half());
            run_random(200);
        end
        write_key(REG_KEY_LOW, '0);
        run_random(50);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // watchdog
    initial
    begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule
